[hdl/xts_pkg.sv]
// XTS block decrypt package: payload structs, sequencer states, AES byte functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package xts_pkg;

  localparam int unsigned KeyWords    = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned RkDepth     = 30;
  localparam int unsigned RkIdxW      = 5;
  localparam logic [7:0]  GfFeedback  = 8'd135;
  localparam logic        OpStart     = 1'b0;
  localparam logic        OpData      = 1'b1;

  typedef struct packed {
    logic        op;
    logic        key_size_256;
    logic [63:0] block_lo;
    logic [63:0] block_hi;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] plain_lo;
    logic [63:0] plain_hi;
    logic        no_sector_error;
    logic        sector_done;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_K1_EXP,
    S_K2_LOAD,
    S_K2_EXP,
    S_ENC_RND,
    S_DEC_PRE,
    S_DEC_RD,
    S_DEC_RND,
    S_OUT
  } state_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (sbox(8'(i)) == x) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit state sits at bits [8i+7:8i]
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] t [16];
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        t[c*4+i] = sbox(s[(((c+i)%4)*4+i)*8 +: 8]);
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (last) begin
        o[32*c +: 32] = {a3, a2, a1, a0};
      end else begin
        o[32*c    +: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        o[32*c+8  +: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        o[32*c+16 +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        o[32*c+24 +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    return o;
  endfunction

  function automatic logic [7:0] mul_e(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
  endfunction
  function automatic logic [7:0] mul_b(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(a) ^ a;
  endfunction
  function automatic logic [7:0] mul_d(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
  endfunction
  function automatic logic [7:0] mul_9(input logic [7:0] a);
    return xt(xt(xt(a))) ^ a;
  endfunction

  // inverse shift + inverse sbox + key, then inverse mix unless last
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [127:0] t;
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        t[(((c+i)%4)*4+i)*8 +: 8] = inv_sbox(s[(c*4+i)*8 +: 8]);
    t = t ^ k;
    for (int c = 0; c < 4; c++) begin
      a0 = t[32*c +: 8]; a1 = t[32*c+8 +: 8]; a2 = t[32*c+16 +: 8]; a3 = t[32*c+24 +: 8];
      if (last) begin
        o[32*c +: 32] = t[32*c +: 32];
      end else begin
        o[32*c    +: 8] = mul_e(a0) ^ mul_b(a1) ^ mul_d(a2) ^ mul_9(a3);
        o[32*c+8  +: 8] = mul_9(a0) ^ mul_e(a1) ^ mul_b(a2) ^ mul_d(a3);
        o[32*c+16 +: 8] = mul_d(a0) ^ mul_9(a1) ^ mul_e(a2) ^ mul_b(a3);
        o[32*c+24 +: 8] = mul_b(a0) ^ mul_d(a1) ^ mul_9(a2) ^ mul_e(a3);
      end
    end
    return o;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] n);
    logic [7:0] r;
    case (n)
      4'd1: r = 8'h01;  4'd2: r = 8'h02;  4'd3: r = 8'h04;  4'd4: r = 8'h08;
      4'd5: r = 8'h10;  4'd6: r = 8'h20;  4'd7: r = 8'h40;  4'd8: r = 8'h80;
      4'd9: r = 8'h1b;  4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage
`default_nettype wire

[hdl/xts_ram.sv]
// Generic single-port-write RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module xts_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 30
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/xts_keyexp.sv]
// AES key schedule stepper: one 32-bit schedule word per cycle while step is high, over a sliding window.
// Depends on xts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xts_keyexp (
  input  wire logic         clk,
  input  wire logic         load,
  input  wire logic         step,
  input  wire logic         wide,
  input  wire logic [255:0] key,
  output      logic [255:0] win,
  output      logic [31:0]  word_new,
  output      logic [5:0]   idx
);
  import xts_pkg::*;

  logic [31:0] t, prev, back;
  logic [2:0]  nmod;
  logic [3:0]  rnum;

  // win holds the last nk words, word 0 oldest; idx is the index of the next word
  always_comb begin
    prev = wide ? win[255:224] : win[127:96];
    back = win[31:0];
    nmod = wide ? idx[2:0] : {1'b0, idx[1:0]};
    rnum = wide ? 4'(idx[5:3]) : idx[5:2];
    t = prev;
    if (nmod == 3'd0) begin
      t = sub_word({prev[7:0], prev[31:8]}) ^ {24'd0, rcon(rnum)};
    end else if (wide && nmod == 3'd4) begin
      t = sub_word(prev);
    end
    word_new = back ^ t;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      win <= key;
      idx <= wide ? 6'd8 : 6'd4;
    end else if (step) begin
      if (wide) win <= {word_new, win[255:32]};
      else      win <= {128'd0, word_new, win[127:32]};
      idx <= idx + 6'd1;
    end
  end
endmodule
`default_nettype wire

[hdl/xts_block_decrypt.sv]
// XTS block decrypt top level: sequencer, shared round unit, tweak register, key store.
// Depends on xts_pkg, xts_keyexp, xts_ram.
//
// Channels: in (in_valid/in_ready, in_item_t), out (out_valid/out_ready, out_item_t),
// cfg (cfg_valid/cfg_ready, cfg_index, cfg_data) writing key_word_0..7; always ready.
// A start transfer (op 0) expands K1 into the round-key RAM one schedule word per cycle
// (44 or 60 words), then expands K2 and encrypts the tweak, one round each time the
// schedule completes a round key; it gives no result.
// A data transfer with an open sector: S_DEC_PRE sets the first key read, then each
// inverse round takes S_DEC_RD and then S_DEC_RND, its round key being two RAM words
// read in turn. Data with no open sector goes straight to S_OUT for its error result.
// The shared unit is the single round datapath and the single RAM read port; this sets
// the rate.
// The result is held in an output register; in_ready stays low until it is taken, so a
// stalled receiver stalls the input. Reset (rst, synchronous) closes the sector, zeroes
// the tweak and keys; the round-key RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module xts_block_decrypt #(
  parameter int unsigned RkDepthP = xts_pkg::RkDepth
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire xts_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      xts_pkg::out_item_t out_data,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);
  import xts_pkg::*;

  localparam int unsigned AW = $clog2(RkDepthP);

  state_t state, state_next;
  logic [63:0]  key_word [KeyWords];
  logic [127:0] tweak;
  logic         sector_open, wide;
  logic [127:0] s;
  logic         last;
  logic [3:0]   rnd;
  logic [63:0]  rk_lo;
  logic [31:0]  half_buf;
  logic [AW-1:0] raddr;
  logic [63:0]  rdata;
  logic         we;
  logic [AW-1:0] waddr;
  logic [63:0]  wdata;
  logic         ke_load, ke_step, ke_wide;
  logic [255:0] ke_key, ke_win;
  logic [31:0]  ke_new;
  logic [5:0]   ke_idx;
  logic [5:0]   ke_total;
  logic [255:0] k2;
  logic         in_fire;
  logic         rk_ready;
  logic [127:0] enc_key;
  logic         rk_seen;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    k2 = '0;
    if (wide) begin
      for (int i = 0; i < 4; i++) k2[64*i +: 64] = key_word[4+i];
    end else begin
      k2[127:0] = {key_word[3], key_word[2]};
    end
  end

  assign ke_wide  = (state == S_IDLE) ? in_data.key_size_256 : wide;
  assign ke_key   = (state == S_IDLE) ? (in_data.key_size_256 ?
                    {key_word[3], key_word[2], key_word[1], key_word[0]} :
                    {128'd0, key_word[1], key_word[0]}) : k2;
  assign ke_total = wide ? 6'd60 : 6'd44;

  xts_keyexp u_ke (
    .clk, .load(ke_load), .step(ke_step), .wide(ke_wide), .key(ke_key),
    .win(ke_win), .word_new(ke_new), .idx(ke_idx)
  );

  xts_ram #(.Width(64), .Depth(RkDepthP)) u_rk (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // K1 words go to RAM in pairs; the first nk words come straight from the key
  logic [5:0] wcnt;
  logic [31:0] wword;
  logic [5:0]  nkw;
  assign nkw = wide ? 6'd8 : 6'd4;
  always_comb begin
    if (wcnt < nkw) wword = ke_win[32*wcnt[2:0] +: 32];
    else            wword = ke_new;
    we    = (state == S_K1_EXP) && wcnt[0];
    waddr = AW'(wcnt[5:1]);
    wdata = {wword, half_buf};
  end

  always_comb begin
    state_next = state;
    ke_load = 1'b0;
    ke_step = 1'b0;
    case (state)
      S_IDLE: if (in_fire) begin
        if (in_data.op == OpStart) begin
          ke_load = 1'b1;
          state_next = S_K1_EXP;
        end else if (sector_open) begin
          state_next = S_DEC_PRE;
        end else begin
          state_next = S_OUT;
        end
      end
      S_K1_EXP: begin
        ke_step = (wcnt >= nkw);
        if (wcnt == ke_total - 6'd1) state_next = S_K2_LOAD;
      end
      S_K2_LOAD: begin
        ke_load = 1'b1;
        state_next = S_K2_EXP;
      end
      S_K2_EXP: state_next = S_ENC_RND;
      S_ENC_RND: begin
        ke_step = 1'b1;
        if (rnd == (wide ? 4'd14 : 4'd10) && rk_ready) state_next = S_IDLE;
      end
      S_DEC_PRE: state_next = S_DEC_RD;
      S_DEC_RD:  state_next = S_DEC_RND;
      S_DEC_RND: state_next = (rnd == 4'd0) ? S_OUT : S_DEC_RD;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Tweak encryption: the K2 schedule is stepped four words per round key; a round key
  // is taken when the window's newest four words complete it. At 256 bits the second
  // round key is already in the loaded window.
  always_comb begin
    rk_ready = (ke_idx[1:0] == 2'd3) || (wide && rnd == 4'd1);
    if (wide && rnd == 4'd1) enc_key = ke_win[255:128];
    else if (wide)           enc_key = {ke_new, ke_win[255:160]};
    else                     enc_key = {ke_new, ke_win[127:32]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_open <= 1'b0;
      wide <= 1'b0;
      tweak <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < KeyWords; i++) key_word[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) key_word[cfg_index] <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_fire) begin
          last <= in_data.last_block;
          wcnt <= '0;
          if (in_data.op == OpStart) begin
            wide <= in_data.key_size_256;
            s <= {in_data.block_hi, in_data.block_lo};
          end else begin
            s <= {in_data.block_hi, in_data.block_lo} ^ tweak;
            rnd <= wide ? 4'd14 : 4'd10;
          end
        end
        S_K1_EXP: begin
          wcnt <= wcnt + 6'd1;
          half_buf <= wword;
        end
        S_K2_EXP: begin
          // first round key is the key itself (words 0-3)
          s <= s ^ ke_win[127:0];
          rnd <= 4'd1;
        end
        S_ENC_RND: begin
          if (rk_ready) begin
            s <= enc_round(s, rnd == (wide ? 4'd14 : 4'd10)) ^ enc_key;
            rnd <= rnd + 4'd1;
            if (rnd == (wide ? 4'd14 : 4'd10)) begin
              tweak <= enc_round(s, 1'b1) ^ enc_key;
              sector_open <= 1'b1;
            end
          end
        end
        S_DEC_PRE: ;
        S_DEC_RD: rk_lo <= rdata;
        S_DEC_RND: begin
          if (!rk_seen) s <= s ^ {rdata, rk_lo};
          else s <= dec_round(s, {rdata, rk_lo}, rnd == 4'd0);
          rnd <= rnd - 4'd1;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_data.sector_done <= last;
          if (sector_open) begin
            out_data.plain_lo <= s[63:0] ^ tweak[63:0];
            out_data.plain_hi <= s[127:64] ^ tweak[127:64];
            out_data.no_sector_error <= 1'b0;
            if (last) sector_open <= 1'b0;
            else tweak <= {tweak[126:0], 1'b0} ^ {120'd0, tweak[127] ? GfFeedback : 8'd0};
          end else begin
            out_data.plain_lo <= '0;
            out_data.plain_hi <= '0;
            out_data.no_sector_error <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // round key r lives in RAM words 2r, 2r+1; the first (initial add) pass is flagged
  always_ff @(posedge clk) begin
    if (rst) begin
      rk_seen <= 1'b0;
    end else if (state == S_IDLE) begin
      rk_seen <= 1'b0;
    end else if (state == S_DEC_RND) begin
      rk_seen <= 1'b1;
    end
  end

  // key index: rnd while loading its two words, rnd-1 while its round runs
  logic [3:0] ridx;
  assign ridx = (state == S_DEC_RND && rnd != 4'd0) ? rnd - 4'd1 : rnd;
  assign raddr = AW'({ridx, state == S_DEC_RD});
endmodule
`default_nettype wire

[hdl/xts_checker.sv]
// Port-level checker for xts_block_decrypt, bound to the top level.
// Depends on xts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xts_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire xts_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire xts_pkg::out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input transfer dropped or changed while waiting");
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result waits");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken during work");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.no_sector_error |-> out_data.plain_lo == 64'd0 &&
    out_data.plain_hi == 64'd0)
    else $error("error result carries data");
endmodule

bind xts_block_decrypt xts_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
);
`default_nettype wire
